/* design/secps_pkg.sv */
// Shared types and constants for the soft-edge convex polygon shader.
// Used by the shader top level and its port checker; no dependencies.
`timescale 1ns / 1ps

package secps_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_BACKGROUND = 3'd0;
    localparam logic [2:0] REG_FOREGROUND = 3'd1;
    localparam logic [2:0] REG_VCOUNT     = 3'd2;
    localparam logic [2:0] REG_WIDTH      = 3'd3;
    localparam logic [2:0] REG_OFFSET_X   = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd5;

    // Input item kinds.
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam int NRM_W      = 16;  // Q2.14 normal component
    localparam int MAG_W      = 17;  // edge vector magnitude after scaling
    localparam int SQ_W       = 35;  // ax^2 + ay^2
    localparam int RAD_W      = 64;  // radicand of the length root
    localparam int ROOT_W     = 32;  // length, 14 fraction bits
    localparam int QT_W       = 15;  // normal quotient bits
    localparam int NUM_W      = 46;  // (a << 28) + len / 2
    localparam int LEN_SHIFT  = 28;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;
    localparam int STEP_W     = 5;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int WIDTH_W    = 12;
    localparam int BAND_SHIFT = 14;
    localparam int BAND_W     = 26;  // soft width in distance units
    localparam int BPROD_W    = 34;
    localparam int BY_W       = 20;
    localparam int BLEND_STEPS = 8;
    localparam int DIST_START_PIX = 10;
    localparam int DIST_FRAC  = 18;
    localparam int COLOR_W    = 24;

    typedef logic [COLOR_W-1:0] color_t;

endpackage

/* design/secps_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for the vertex and edge normal stores of the shader.
`timescale 1ns / 1ps

module secps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/soft_edge_convex_polygon_shader.sv */
// Soft-edge convex polygon shader: vertex store, edge normal unit and pixel blender.
// Depends on secps_pkg and secps_ram.
`timescale 1ns / 1ps

// The block keeps up to MAX_VERTICES polygon vertices and the unit normal of every
// edge in two small RAMs with a registered read. A vertex transfer (kind 0) stores
// the vertex plus the offset, saturated to COORD_WIDTH bits, and, when its slot is
// below the active vertex count, rebuilds the normals of both edges that meet at
// it. Each normal goes through one shared multiplier, a bit-serial square root and
// a 15-step divider; a zero-length edge skips the divider. A vertex transfer whose
// slot is at or beyond the count rebuilds no normal and leaves the block idle. A
// pixel transfer (kind 1) streams the active edges out of the RAMs, one edge per
// cycle, through a multiply stage and a running minimum; when the pixel falls in
// the soft band, an 8-step divider per color channel forms the blend. The block
// works on one item at a time: in_ready is high only while it is idle. The result
// sits in an output register, so the next item may be taken while the previous
// color still waits for out_ready. Configuration writes are expected only while
// idle. Vertices that were never written read as undefined values.

module soft_edge_convex_polygon_shader #(
    parameter int MAX_VERTICES = 9,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [23:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [3:0]          vertex_index,
    input  logic signed [15:0]  vertex_x,
    input  logic signed [15:0]  vertex_y,
    input  logic [11:0]         pixel_column,
    input  logic [11:0]         pixel_row,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [23:0]         pixel_color
);

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CW     = COORD_WIDTH;
    localparam int DIFF_W = CW + 1;
    localparam int SUM_W  = ((CW > 17) ? CW : 17) + 1;
    localparam int DX_W   = ((CW > 18) ? CW : 18) + 1;
    localparam int P_W    = secps_pkg::NRM_W + DX_W;
    localparam int D_W    = P_W + 1;
    localparam int MAG_W  = secps_pkg::MAG_W;
    localparam int ROOT_W = secps_pkg::ROOT_W;
    localparam int QT_W   = secps_pkg::QT_W;
    localparam int NUM_W  = secps_pkg::NUM_W;
    localparam int NRM_W  = secps_pkg::NRM_W;
    localparam int BAND_W = secps_pkg::BAND_W;
    localparam int CH_W   = secps_pkg::CH_W;
    localparam int NUM_CH = secps_pkg::NUM_CH;
    localparam int WIDTH_W = secps_pkg::WIDTH_W;

    localparam logic signed [SUM_W-1:0] C_HI = SUM_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] C_LO = -C_HI - SUM_W'(1);
    localparam logic signed [D_W-1:0] DIST_START =
        D_W'(secps_pkg::DIST_START_PIX) <<< secps_pkg::DIST_FRAC;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_VRD    = 4'd1;
    localparam logic [3:0] ST_VWAIT  = 4'd2;
    localparam logic [3:0] ST_NORM   = 4'd3;
    localparam logic [3:0] ST_SQ1    = 4'd4;
    localparam logic [3:0] ST_SQ2    = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_DSET   = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_NWR    = 4'd9;
    localparam logic [3:0] ST_PSCAN  = 4'd10;
    localparam logic [3:0] ST_PDRAIN = 4'd11;
    localparam logic [3:0] ST_BMUL   = 4'd12;
    localparam logic [3:0] ST_BSUM   = 4'd13;
    localparam logic [3:0] ST_BDIV   = 4'd14;
    localparam logic [3:0] ST_OUT    = 4'd15;

    // Configuration registers.
    secps_pkg::color_t        background_color_reg;
    secps_pkg::color_t        foreground_color_reg;
    logic [3:0]               vertex_count_reg;
    logic [WIDTH_W-1:0]       soft_width_reg;
    logic signed [15:0]       offset_x_reg;
    logic signed [15:0]       offset_y_reg;

    // Control state.
    logic [3:0]  state_reg, state_next;
    logic        pass_reg, pass_next;
    logic        rd_valid_reg, rd_valid_next;
    logic        prod_valid_reg, prod_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [secps_pkg::STEP_W-1:0] step_reg, step_next;
    logic [AW-1:0] addr_reg, addr_next;

    // Payload state.
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           prev_reg, prev_next;
    logic [AW-1:0]           nidx_reg, nidx_next;
    logic signed [CW-1:0]    new_x_reg, new_x_next;
    logic signed [CW-1:0]    new_y_reg, new_y_next;
    logic [DIFF_W-1:0]       ax_reg, ax_next;
    logic [DIFF_W-1:0]       ay_reg, ay_next;
    logic                    ux_neg_reg, ux_neg_next;
    logic                    uy_neg_reg, uy_neg_next;
    logic [secps_pkg::SQ_W-1:0]  sq_reg, sq_next;
    logic [secps_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [secps_pkg::SQ_W-1:0]  srem_reg, srem_next;
    logic [ROOT_W-1:0]       dremx_reg, dremx_next;
    logic [ROOT_W-1:0]       dremy_reg, dremy_next;
    logic [QT_W-1:0]         dlowx_reg, dlowx_next;
    logic [QT_W-1:0]         dlowy_reg, dlowy_next;
    logic [MAG_W-1:0]        cx_reg, cx_next;
    logic [MAG_W-1:0]        cy_reg, cy_next;
    logic signed [P_W-1:0]   prodx_reg, prodx_next;
    logic signed [P_W-1:0]   prody_reg, prody_next;
    logic signed [D_W-1:0]   t_reg, t_next;
    logic [BAND_W-1:0]       a_reg, a_next;
    logic [secps_pkg::BPROD_W-1:0] bp0_reg [NUM_CH];
    logic [secps_pkg::BPROD_W-1:0] bp0_next [NUM_CH];
    logic [secps_pkg::BPROD_W-1:0] bp1_reg [NUM_CH];
    logic [secps_pkg::BPROD_W-1:0] bp1_next [NUM_CH];
    logic [WIDTH_W-1:0]      brem_reg [NUM_CH];
    logic [WIDTH_W-1:0]      brem_next [NUM_CH];
    logic [CH_W-1:0]         bq_reg [NUM_CH];
    logic [CH_W-1:0]         bq_next [NUM_CH];
    secps_pkg::color_t       res_reg, res_next;
    secps_pkg::color_t       pixel_color_reg, pixel_color_next;

    // RAM ports.
    logic               vmem_we;
    logic [AW-1:0]      vmem_raddr;
    logic [2*CW-1:0]    vmem_wdata;
    logic [2*CW-1:0]    vmem_rdata;
    logic               nmem_we;
    logic [2*NRM_W-1:0] nmem_wdata;
    logic [2*NRM_W-1:0] nmem_rdata;

    // Helpers.
    logic               in_xfer;
    logic [4:0]         vc5;
    logic [4:0]         n_act;
    logic [4:0]         idx5;
    logic               idx_stored;
    logic               idx_active;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [CW-1:0]    sat_x;
    logic signed [CW-1:0]    sat_y;
    logic signed [CW-1:0]    mem_x;
    logic signed [CW-1:0]    mem_y;
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic [MAG_W-1:0]   mul_in;
    logic [2*MAG_W-1:0] sq_prod;
    logic [MAG_W-1:0]   ax17;
    logic [MAG_W-1:0]   ay17;
    logic [secps_pkg::SQ_W-1:0] s_t2;
    logic [secps_pkg::SQ_W-1:0] s_tr;
    logic [NUM_W-1:0]   numx;
    logic [NUM_W-1:0]   numy;
    logic [ROOT_W:0]    dtx;
    logic [ROOT_W:0]    dty;
    logic               gex;
    logic               gey;
    logic [NRM_W-1:0]   nx16;
    logic [NRM_W-1:0]   ny16;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic signed [D_W-1:0]  edge_dist;
    logic [WIDTH_W-1:0] w_eff;
    logic [BAND_W-1:0]  band;
    logic signed [D_W-1:0] band_s;
    logic [secps_pkg::BPROD_W:0] bsum;
    logic [secps_pkg::BY_W-1:0]  by;
    logic [WIDTH_W:0]   btrial;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] s);
        logic signed [CW-1:0] r;
        if (s > C_HI)
            r = CW'(C_HI);
        else if (s < C_LO)
            r = CW'(C_LO);
        else
            r = CW'(s);
        return r;
    endfunction

    secps_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_vertex_ram (
        .clk   (clk),
        .we    (vmem_we),
        .waddr (AW'(vertex_index)),
        .wdata (vmem_wdata),
        .raddr (vmem_raddr),
        .rdata (vmem_rdata)
    );

    secps_ram #(.WIDTH(2 * NRM_W), .DEPTH(MAX_VERTICES)) u_normal_ram (
        .clk   (clk),
        .we    (nmem_we),
        .waddr (pass_reg ? idx_reg : prev_reg),
        .wdata (nmem_wdata),
        .raddr (vmem_raddr),
        .rdata (nmem_rdata)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_color_reg;

    // Active vertex count, clamped to three up to the store depth.
    assign vc5   = {1'b0, vertex_count_reg};
    assign n_act = (vc5 < 5'd3) ? 5'd3 :
                   ((vc5 > 5'(MAX_VERTICES)) ? 5'(MAX_VERTICES) : vc5);
    assign idx5       = {1'b0, vertex_index};
    assign idx_stored = idx5 < 5'(MAX_VERTICES);
    assign idx_active = idx5 < n_act;

    assign sum_x = SUM_W'(vertex_x) + SUM_W'(offset_x_reg);
    assign sum_y = SUM_W'(vertex_y) + SUM_W'(offset_y_reg);
    assign sat_x = sat_coord(sum_x);
    assign sat_y = sat_coord(sum_y);

    // The vertex is written on the transfer edge; the neighbors are read later by
    // the sequencer, and pixels read only after the normals are written back, so
    // no two accesses to one entry ever overlap.
    assign vmem_we    = in_xfer && (kind == secps_pkg::KIND_VERTEX) && idx_stored;
    assign vmem_wdata = {sat_y, sat_x};
    assign vmem_raddr = (state_reg == ST_PSCAN) ? addr_reg :
                        (pass_reg ? nidx_reg : prev_reg);

    assign mem_x = $signed(vmem_rdata[CW-1:0]);
    assign mem_y = $signed(vmem_rdata[2*CW-1:CW]);

    // Edge vector (-(dy), dx) of the edge from vertex e to its successor. On the
    // first pass the edge ends at the new vertex, on the second it starts there.
    assign ux = pass_reg ? (DIFF_W'(new_y_reg) - DIFF_W'(mem_y))
                         : (DIFF_W'(mem_y) - DIFF_W'(new_y_reg));
    assign uy = pass_reg ? (DIFF_W'(mem_x) - DIFF_W'(new_x_reg))
                         : (DIFF_W'(new_x_reg) - DIFF_W'(mem_x));

    assign ax17    = MAG_W'(ax_reg);
    assign ay17    = MAG_W'(ay_reg);
    assign mul_in  = (state_reg == ST_SQ1) ? ax17 : ay17;
    assign sq_prod = mul_in * mul_in;

    // One root bit per cycle.
    assign s_t2 = {srem_reg[32:0], rad_reg[secps_pkg::RAD_W-1 -: 2]};
    assign s_tr = {1'b0, root_reg, 2'b01};

    assign numx = {ax17, {secps_pkg::LEN_SHIFT{1'b0}}} + NUM_W'(root_reg >> 1);
    assign numy = {ay17, {secps_pkg::LEN_SHIFT{1'b0}}} + NUM_W'(root_reg >> 1);

    // One quotient bit per cycle for each normal component.
    assign dtx = {dremx_reg, dlowx_reg[QT_W-1]};
    assign dty = {dremy_reg, dlowy_reg[QT_W-1]};
    assign gex = dtx >= {1'b0, root_reg};
    assign gey = dty >= {1'b0, root_reg};

    assign nx16 = ux_neg_reg ? (NRM_W'(0) - NRM_W'(dlowx_reg)) : NRM_W'(dlowx_reg);
    assign ny16 = uy_neg_reg ? (NRM_W'(0) - NRM_W'(dlowy_reg)) : NRM_W'(dlowy_reg);

    // A zero-length edge gets a zero normal.
    assign nmem_we    = (state_reg == ST_NWR);
    assign nmem_wdata = (root_reg == '0) ? '0 : {ny16, nx16};

    // Pixel center offsets from the stored vertex.
    assign dx = DX_W'($signed({1'b0, cx_reg})) - DX_W'(mem_x);
    assign dy = DX_W'($signed({1'b0, cy_reg})) - DX_W'(mem_y);
    assign edge_dist = D_W'(prodx_reg) + D_W'(prody_reg);

    assign w_eff  = (soft_width_reg == '0) ? WIDTH_W'(1) : soft_width_reg;
    assign band   = {w_eff, {secps_pkg::BAND_SHIFT{1'b0}}};
    assign band_s = D_W'($signed({1'b0, band}));

    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        rd_valid_next    = 1'b0;
        prod_valid_next  = rd_valid_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        step_next        = step_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        prev_next        = prev_reg;
        nidx_next        = nidx_reg;
        new_x_next       = new_x_reg;
        new_y_next       = new_y_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        ux_neg_next      = ux_neg_reg;
        uy_neg_next      = uy_neg_reg;
        sq_next          = sq_reg;
        rad_next         = rad_reg;
        root_next        = root_reg;
        srem_next        = srem_reg;
        dremx_next       = dremx_reg;
        dremy_next       = dremy_reg;
        dlowx_next       = dlowx_reg;
        dlowy_next       = dlowy_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        prodx_next       = P_W'($signed(nmem_rdata[NRM_W-1:0])) * P_W'(dx);
        prody_next       = P_W'($signed(nmem_rdata[2*NRM_W-1:NRM_W])) * P_W'(dy);
        t_next           = t_reg;
        a_next           = a_reg;
        res_next         = res_reg;
        pixel_color_next = pixel_color_reg;
        bsum             = '0;
        by               = '0;
        btrial           = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            bp0_next[c]  = bp0_reg[c];
            bp1_next[c]  = bp1_reg[c];
            brem_next[c] = brem_reg[c];
            bq_next[c]   = bq_reg[c];
        end

        // Running minimum over the edge stream.
        if (prod_valid_reg && (edge_dist < t_reg))
        begin
            t_next = edge_dist;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == secps_pkg::KIND_PIXEL)
                    begin
                        cx_next    = MAG_W'({pixel_column, 4'b1000});
                        cy_next    = MAG_W'({pixel_row, 4'b1000});
                        t_next     = DIST_START;
                        addr_next  = '0;
                        state_next = ST_PSCAN;
                    end
                    else
                    begin
                        idx_next   = AW'(vertex_index);
                        prev_next  = (idx5 == 5'd0) ? AW'(n_act - 5'd1) : AW'(idx5 - 5'd1);
                        nidx_next  = ((idx5 + 5'd1) == n_act) ? '0 : AW'(idx5 + 5'd1);
                        new_x_next = sat_x;
                        new_y_next = sat_y;
                        pass_next  = 1'b0;
                        if (idx_stored && idx_active)
                        begin
                            state_next = ST_VRD;
                        end
                    end
                end
            end

            ST_VRD:
            begin
                state_next = ST_VWAIT;
            end

            ST_VWAIT:
            begin
                ux_neg_next = ux < 0;
                uy_neg_next = uy < 0;
                ax_next     = (ux < 0) ? DIFF_W'(-ux) : DIFF_W'(ux);
                ay_next     = (uy < 0) ? DIFF_W'(-uy) : DIFF_W'(uy);
                state_next  = ST_NORM;
            end

            ST_NORM:
            begin
                // Scale long edges down until both parts fit in 17 bits.
                if (((ax_reg | ay_reg) >> MAG_W) != '0)
                begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end
                else
                begin
                    state_next = ST_SQ1;
                end
            end

            ST_SQ1:
            begin
                sq_next    = secps_pkg::SQ_W'(sq_prod);
                state_next = ST_SQ2;
            end

            ST_SQ2:
            begin
                sq_next    = sq_reg + secps_pkg::SQ_W'(sq_prod);
                rad_next   = {1'b0, sq_next, {secps_pkg::LEN_SHIFT{1'b0}}};
                root_next  = '0;
                srem_next  = '0;
                step_next  = '0;
                state_next = ST_SQRT;
            end

            ST_SQRT:
            begin
                if (s_t2 >= s_tr)
                begin
                    srem_next = s_t2 - s_tr;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = s_t2;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = rad_reg << 2;
                step_next = step_reg + 1'b1;
                if (step_reg == secps_pkg::STEP_W'(secps_pkg::SQRT_STEPS - 1))
                begin
                    state_next = ST_DSET;
                end
            end

            ST_DSET:
            begin
                dremx_next = ROOT_W'(numx >> QT_W);
                dremy_next = ROOT_W'(numy >> QT_W);
                dlowx_next = numx[QT_W-1:0];
                dlowy_next = numy[QT_W-1:0];
                step_next  = '0;
                state_next = (root_reg == '0) ? ST_NWR : ST_DIV;
            end

            ST_DIV:
            begin
                dremx_next = gex ? ROOT_W'(dtx - {1'b0, root_reg}) : dtx[ROOT_W-1:0];
                dremy_next = gey ? ROOT_W'(dty - {1'b0, root_reg}) : dty[ROOT_W-1:0];
                dlowx_next = {dlowx_reg[QT_W-2:0], gex};
                dlowy_next = {dlowy_reg[QT_W-2:0], gey};
                step_next  = step_reg + 1'b1;
                if (step_reg == secps_pkg::STEP_W'(secps_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_NWR;
                end
            end

            ST_NWR:
            begin
                if (pass_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pass_next  = 1'b1;
                    state_next = ST_VRD;
                end
            end

            ST_PSCAN:
            begin
                rd_valid_next = 1'b1;
                if (5'(addr_reg) == (n_act - 5'd1))
                begin
                    state_next = ST_PDRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_PDRAIN:
            begin
                if (!rd_valid_reg && !prod_valid_reg)
                begin
                    if (t_reg < -band_s)
                    begin
                        res_next   = background_color_reg;
                        state_next = ST_OUT;
                    end
                    else if (t_reg > 0)
                    begin
                        res_next   = foreground_color_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        a_next     = BAND_W'(-t_reg);
                        state_next = ST_BMUL;
                    end
                end
            end

            ST_BMUL:
            begin
                // Channel = (bg * (-t) + fg * (band + t)) / band, per lane.
                for (int c = 0; c < NUM_CH; c++)
                begin
                    bp0_next[c] = background_color_reg[CH_W*(NUM_CH-1-c) +: CH_W] * a_reg;
                    bp1_next[c] = foreground_color_reg[CH_W*(NUM_CH-1-c) +: CH_W]
                                  * (band - a_reg);
                end
                state_next = ST_BSUM;
            end

            ST_BSUM:
            begin
                // Dividing by band is a shift by 14 followed by a divide by the width.
                for (int c = 0; c < NUM_CH; c++)
                begin
                    bsum         = {1'b0, bp0_reg[c]} + {1'b0, bp1_reg[c]};
                    by           = secps_pkg::BY_W'(bsum >> secps_pkg::BAND_SHIFT);
                    brem_next[c] = WIDTH_W'(by >> CH_W);
                    bq_next[c]   = by[CH_W-1:0];
                end
                step_next  = '0;
                state_next = ST_BDIV;
            end

            ST_BDIV:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    btrial = {brem_reg[c], bq_reg[c][CH_W-1]};
                    if (btrial >= {1'b0, w_eff})
                    begin
                        brem_next[c] = WIDTH_W'(btrial - {1'b0, w_eff});
                        bq_next[c]   = {bq_reg[c][CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        brem_next[c] = btrial[WIDTH_W-1:0];
                        bq_next[c]   = {bq_reg[c][CH_W-2:0], 1'b0};
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == secps_pkg::STEP_W'(secps_pkg::BLEND_STEPS - 1))
                begin
                    res_next   = {bq_next[0], bq_next[1], bq_next[2]};
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    pixel_color_next = res_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            pass_reg             <= 1'b0;
            rd_valid_reg         <= 1'b0;
            prod_valid_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
            step_reg             <= '0;
            addr_reg             <= '0;
            background_color_reg <= '0;
            foreground_color_reg <= 24'hFFFFFF;
            vertex_count_reg     <= 4'd3;
            soft_width_reg       <= WIDTH_W'(16);
            offset_x_reg         <= '0;
            offset_y_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            rd_valid_reg   <= rd_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
            addr_reg       <= addr_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    secps_pkg::REG_BACKGROUND: background_color_reg <= cfg_wdata;
                    secps_pkg::REG_FOREGROUND: foreground_color_reg <= cfg_wdata;
                    secps_pkg::REG_VCOUNT:     vertex_count_reg     <= cfg_wdata[3:0];
                    secps_pkg::REG_WIDTH:      soft_width_reg       <= cfg_wdata[WIDTH_W-1:0];
                    secps_pkg::REG_OFFSET_X:   offset_x_reg         <= $signed(cfg_wdata[15:0]);
                    secps_pkg::REG_OFFSET_Y:   offset_y_reg         <= $signed(cfg_wdata[15:0]);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        prev_reg        <= prev_next;
        nidx_reg        <= nidx_next;
        new_x_reg       <= new_x_next;
        new_y_reg       <= new_y_next;
        ax_reg          <= ax_next;
        ay_reg          <= ay_next;
        ux_neg_reg      <= ux_neg_next;
        uy_neg_reg      <= uy_neg_next;
        sq_reg          <= sq_next;
        rad_reg         <= rad_next;
        root_reg        <= root_next;
        srem_reg        <= srem_next;
        dremx_reg       <= dremx_next;
        dremy_reg       <= dremy_next;
        dlowx_reg       <= dlowx_next;
        dlowy_reg       <= dlowy_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        prodx_reg       <= prodx_next;
        prody_reg       <= prody_next;
        t_reg           <= t_next;
        a_reg           <= a_next;
        res_reg         <= res_next;
        pixel_color_reg <= pixel_color_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            bp0_reg[c]  <= bp0_next[c];
            bp1_reg[c]  <= bp1_next[c];
            brem_reg[c] <= brem_next[c];
            bq_reg[c]   <= bq_next[c];
        end
    end

endmodule

/* design/secps_checker.sv */
// Port-level assertions for the soft-edge convex polygon shader, with their bind.
// Depends on secps_pkg and the soft_edge_convex_polygon_shader ports.
`timescale 1ns / 1ps

module secps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] pixel_color
);

    // A stalled result stays and holds its color.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_color))
        else $error("stalled result changed");

    // A vertex transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == secps_pkg::KIND_VERTEX) |=> !$rose(out_valid))
        else $error("result appeared after a vertex transfer");

    // A pixel transfer keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == secps_pkg::KIND_PIXEL) |=> !in_ready)
        else $error("block idle right after a pixel transfer");

    // A new result only comes out of a busy block.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind soft_edge_convex_polygon_shader secps_checker u_secps_checker (.*);

/* verif/soft_edge_convex_polygon_shader_tb.sv */
// Self-checking testbench for the soft-edge convex polygon shader.
// Depends on secps_pkg and the soft_edge_convex_polygon_shader top level.
`timescale 1ns / 1ps

module soft_edge_convex_polygon_shader_tb;

    localparam int  VMAX      = 9;
    localparam int  PHASES    = 9;
    localparam int  PHASE_LEN = 190;
    localparam int  SETTLE    = 200;    // covers a full vertex transfer and then some
    localparam longint LIMIT  = 3000000;
    localparam longint DIST_INIT =
        longint'(secps_pkg::DIST_START_PIX) <<< secps_pkg::DIST_FRAC;

    typedef struct {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [11:0] col;
        logic [11:0] row;
    } shader_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = secps_pkg::REG_BACKGROUND;
    logic [23:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = secps_pkg::KIND_VERTEX;
    logic [3:0]  vertex_index = '0;
    logic signed [15:0] vertex_x = '0;
    logic signed [15:0] vertex_y = '0;
    logic [11:0] pixel_column = '0;
    logic [11:0] pixel_row = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [23:0] pixel_color;

    // Shadow copy of the block's configuration and vertex/normal stores.
    secps_pkg::color_t sh_background = 24'h000000;
    secps_pkg::color_t sh_foreground = 24'hFFFFFF;
    logic [3:0]  sh_count = 4'd3;
    logic [11:0] sh_width = 12'd16;
    logic [15:0] sh_off_x = '0;
    logic [15:0] sh_off_y = '0;
    logic signed [15:0] corner_x [VMAX];
    logic signed [15:0] corner_y [VMAX];
    logic signed [15:0] normal_x [VMAX];
    logic signed [15:0] normal_y [VMAX];

    shader_item_t      pending_items[$];
    secps_pkg::color_t expected_colors[$];
    int           error_count = 0;
    longint       cycle_count = 0;
    bit           calm = 1'b0;     // while set, neither side inserts gaps
    int           in_gap = 0;
    int           out_gap = 0;

    soft_edge_convex_polygon_shader u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .vertex_index(vertex_index),
        .vertex_x(vertex_x), .vertex_y(vertex_y),
        .pixel_column(pixel_column), .pixel_row(pixel_row),
        .out_valid(out_valid), .out_ready(out_ready), .pixel_color(pixel_color)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one, none at all while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Vertex count as the block uses it: clamped to 3..VMAX.
    function automatic int live_count();
        int n;
        n = int'(sh_count);
        if (n < 3)
            n = 3;
        if (n > VMAX)
            n = VMAX;
        return n;
    endfunction

    function automatic logic signed [15:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Integer square root, bit by bit, same digit recurrence as a hardware root.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Unit normal of edge e (vertex e to the next one) in Q2.14, rounded half away.
    task automatic rebuild_normal(int e, int n);
        int nx;
        longint ux;
        longint uy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned len;
        longint unsigned qx;
        longint unsigned qy;
        nx = (e + 1 == n) ? 0 : e + 1;
        ux = -(longint'(corner_y[nx]) - longint'(corner_y[e]));
        uy = longint'(corner_x[nx]) - longint'(corner_x[e]);
        ax = (ux < 0) ? -ux : ux;
        ay = (uy < 0) ? -uy : uy;
        while ((ax | ay) >= (64'd1 << secps_pkg::MAG_W))
        begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        len = int_sqrt((ax * ax + ay * ay) << secps_pkg::LEN_SHIFT);
        if (len == 0)
        begin
            normal_x[e] = '0;
            normal_y[e] = '0;
        end
        else
        begin
            qx = ((ax << secps_pkg::LEN_SHIFT) + len / 2) / len;
            qy = ((ay << secps_pkg::LEN_SHIFT) + len / 2) / len;
            normal_x[e] = 16'((ux < 0) ? -longint'(qx) : longint'(qx));
            normal_y[e] = 16'((uy < 0) ? -longint'(qy) : longint'(qy));
        end
    endtask

    function automatic logic [7:0] mix_channel(longint unsigned c0, longint unsigned c1,
                                               longint unsigned num, longint unsigned den);
        return 8'((c0 * (den - num) + c1 * num) / den);
    endfunction

    // Applies one accepted transfer to the shadow state and queues any color it produces.
    task automatic shade_item(shader_item_t it);
        int n;
        int k;
        longint cx;
        longint cy;
        longint edge_dist;
        longint least;
        longint band;
        longint unsigned num;
        secps_pkg::color_t color;
        n = live_count();
        if (it.kind == secps_pkg::KIND_VERTEX)
        begin
            if (it.slot < VMAX)
            begin
                corner_x[it.slot] = clamp_coord(longint'($signed(it.x)) +
                                                longint'($signed(sh_off_x)));
                corner_y[it.slot] = clamp_coord(longint'($signed(it.y)) +
                                                longint'($signed(sh_off_y)));
                if (it.slot < n)
                begin
                    rebuild_normal((it.slot == 0) ? n - 1 : it.slot - 1, n);
                    rebuild_normal(it.slot, n);
                end
            end
        end
        else
        begin
            cx = longint'(it.col) * 16 + 8;
            cy = longint'(it.row) * 16 + 8;
            least = DIST_INIT;
            band = longint'((sh_width == 0) ? 12'd1 : sh_width) <<< secps_pkg::BAND_SHIFT;
            for (k = 0; k < n; k++)
            begin
                edge_dist = longint'(normal_x[k]) * (cx - corner_x[k]) +
                            longint'(normal_y[k]) * (cy - corner_y[k]);
                if (edge_dist < least)
                    least = edge_dist;
            end
            if (least < -band)
                color = sh_background;
            else if (least > 0)
                color = sh_foreground;
            else
            begin
                num = band + least;
                color[23:16] = mix_channel(sh_background[23:16], sh_foreground[23:16], num, band);
                color[15:8]  = mix_channel(sh_background[15:8],  sh_foreground[15:8],  num, band);
                color[7:0]   = mix_channel(sh_background[7:0],   sh_foreground[7:0],   num, band);
            end
            expected_colors.push_back(color);
        end
    endtask

    // Driver: presents queued items; the shadow model is advanced on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        shader_item_t it;
        bit holding;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            holding = in_valid;
            if (in_valid && in_ready)
            begin
                it.kind = kind;
                it.slot = vertex_index;
                it.x    = vertex_x;
                it.y    = vertex_y;
                it.col  = pixel_column;
                it.row  = pixel_row;
                shade_item(it);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    it = pending_items.pop_front();
                    kind <= it.kind;
                    vertex_index <= it.slot;
                    vertex_x <= it.x;
                    vertex_y <= it.y;
                    pixel_column <= it.col;
                    pixel_row <= it.row;
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure on the result side, each color checked in order.
    always @(posedge clk or negedge rst_n)
    begin
        secps_pkg::color_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("pixel_color: unexpected result %06h", pixel_color);
                    error_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (pixel_color !== want)
                    begin
                        $error("pixel_color mismatch: expected %06h, actual %06h",
                               want, pixel_color);
                        error_count++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [23:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        case (addr)
            secps_pkg::REG_BACKGROUND: sh_background = value;
            secps_pkg::REG_FOREGROUND: sh_foreground = value;
            secps_pkg::REG_VCOUNT:     sh_count = value[3:0];
            secps_pkg::REG_WIDTH:      sh_width = value[11:0];
            secps_pkg::REG_OFFSET_X:   sh_off_x = value[15:0];
            secps_pkg::REG_OFFSET_Y:   sh_off_y = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until the input queue is drained and every color is back, then lets
    // a trailing vertex transfer finish, since it produces no result to wait for.
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_vertex(int slot, longint px, longint py);
        shader_item_t it;
        it.kind = secps_pkg::KIND_VERTEX;
        it.slot = 4'(slot);
        it.x    = clamp_coord(px);
        it.y    = clamp_coord(py);
        it.col  = 12'($urandom);
        it.row  = 12'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic add_pixel(int col, int row);
        shader_item_t it;
        it.kind = secps_pkg::KIND_PIXEL;
        it.slot = 4'($urandom);
        it.x    = 16'($urandom);
        it.y    = 16'($urandom);
        it.col  = 12'(col);
        it.row  = 12'(row);
        pending_items.push_back(it);
    endtask

    // Loads a regular polygon with n corners around (cxp, cyp) pixels. Positions
    // are given after the offset, so the offset is taken back out here.
    task automatic add_polygon(int n, int cxp, int cyp, int radius, bit ccw);
        int i;
        real ang;
        real rot;
        longint px;
        longint py;
        rot = $urandom_range(0, 628) / 100.0;
        for (i = 0; i < n; i++)
        begin
            ang = rot + (ccw ? 1.0 : -1.0) * 6.2831853 * i / n;
            px = longint'((cxp + radius * $cos(ang)) * 16.0) - longint'($signed(sh_off_x));
            py = longint'((cyp + radius * $sin(ang)) * 16.0) - longint'($signed(sh_off_y));
            add_vertex(i, px, py);
        end
    endtask

    function automatic int clip_pixel(int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    initial
    begin
        int p;
        int i;
        int n;
        int cxp;
        int cyp;
        int radius;
        int reach;
        int r;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Fill every slot once with all nine vertices live, so no later pixel or
        // normal ever reads a slot that holds no vertex.
        reg_write(secps_pkg::REG_VCOUNT, 24'd9);
        add_polygon(9, 1000, 1000, 300, 1'b1);
        calm = 1'b1;
        drain();

        // Directed part: extreme pixels, the center, the soft band, ignored and
        // parked slots, and a zero-length edge.
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(4095, 0);
        add_pixel(0, 4095);
        add_pixel(1000, 1000);
        add_pixel(1300, 1000);
        add_pixel(1299, 1000);
        add_pixel(1301, 1000);
        add_vertex(12, 16'sh7FFF, 16'sh8000);
        add_vertex(15, 0, 0);
        add_pixel(1000, 700);
        add_pixel(1000, 701);
        drain();
        reg_write(secps_pkg::REG_VCOUNT, 24'd4);
        add_vertex(6, 16'sh8000, 16'sh7FFF);
        add_vertex(0, 900 * 16, 900 * 16);
        add_vertex(1, 900 * 16, 900 * 16);
        add_vertex(2, 1100 * 16, 1100 * 16);
        add_vertex(3, 900 * 16, 1100 * 16);
        add_pixel(950, 1000);
        add_pixel(1000, 1050);
        add_pixel(900, 900);
        calm = 1'b0;
        drain();

        // Random part: each phase picks a setting, loads a polygon and shades
        // mostly pixels around it, with stray vertex writes as noise.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    reg_write(secps_pkg::REG_BACKGROUND, 24'h000000);
                    reg_write(secps_pkg::REG_FOREGROUND, 24'hFFFFFF);
                    reg_write(secps_pkg::REG_VCOUNT, 24'd3);
                    reg_write(secps_pkg::REG_WIDTH, 24'd1);
                    reg_write(secps_pkg::REG_OFFSET_X, 24'h008000);
                    reg_write(secps_pkg::REG_OFFSET_Y, 24'h007FFF);
                end
                1:
                begin
                    reg_write(secps_pkg::REG_BACKGROUND, 24'hFFFFFF);
                    reg_write(secps_pkg::REG_FOREGROUND, 24'h000000);
                    reg_write(secps_pkg::REG_VCOUNT, 24'd15);
                    reg_write(secps_pkg::REG_WIDTH, 24'd4095);
                    reg_write(secps_pkg::REG_OFFSET_X, 24'd0);
                    reg_write(secps_pkg::REG_OFFSET_Y, 24'd0);
                end
                2:
                begin
                    reg_write(secps_pkg::REG_VCOUNT, 24'd0);
                    reg_write(secps_pkg::REG_WIDTH, 24'd0);
                    reg_write(secps_pkg::REG_OFFSET_X, 24'h00FFF0);
                    reg_write(secps_pkg::REG_OFFSET_Y, 24'h000010);
                end
                default:
                begin
                    reg_write(secps_pkg::REG_BACKGROUND, 24'($urandom));
                    reg_write(secps_pkg::REG_FOREGROUND, 24'($urandom));
                    reg_write(secps_pkg::REG_VCOUNT, 24'($urandom_range(3, 9)));
                    reg_write(secps_pkg::REG_WIDTH, 24'($urandom_range(1, 800)));
                    reg_write(secps_pkg::REG_OFFSET_X, 24'($urandom_range(0, 8000) - 4000));
                    reg_write(secps_pkg::REG_OFFSET_Y, 24'($urandom_range(0, 8000) - 4000));
                end
            endcase
            calm = (p == 4);
            n = live_count();
            cxp = $urandom_range(200, 1800);
            cyp = $urandom_range(200, 1800);
            radius = $urandom_range(2, 180);
            add_polygon(n, cxp, cyp, radius, $urandom_range(99) < 85);
            reach = radius + live_count() + ((sh_width == 0) ? 1 : sh_width) / 16 + 6;
            for (i = 0; i < PHASE_LEN; i++)
            begin
                r = $urandom_range(99);
                if (r < 88)
                    add_pixel(clip_pixel(cxp + $urandom_range(0, 2 * reach) - reach),
                              clip_pixel(cyp + $urandom_range(0, 2 * reach) - reach));
                else if (r < 94)
                    add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                else
                    add_vertex($urandom_range(0, 15), $signed(16'($urandom)),
                               $signed(16'($urandom)));
            end
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
